[src/bbrs_pkg.sv]
package bbrs_pkg;

  // Q16.16 word widths.
  localparam int unsigned PotW  = 32;
  localparam int unsigned MagW  = 31;
  localparam int unsigned IterW = 16;
  localparam int unsigned FracW = 16;

  localparam logic signed [PotW-1:0] GreatQ  = 32'sh7FFF_FFFF;
  localparam logic signed [PotW-1:0] MinQ    = 32'sh8000_0000;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_TRY       = 2'd0,
    ST_CONVERGED = 2'd1,
    ST_FAILED    = 2'd2,
    ST_IDLE      = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_INITIAL_STEP   = 3'd0,
    REG_MAX_STEP       = 3'd1,
    REG_MAX_ITERATIONS = 3'd2,
    REG_ABS_TOLERANCE  = 3'd3,
    REG_REL_TOLERANCE  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [MagW-1:0]  initial_step;
    logic [MagW-1:0]  max_step;
    logic [IterW-1:0] max_iterations;
    logic [MagW-1:0]  abs_tolerance;
    logic [FracW-1:0] rel_tolerance;
  } cfg_t;

  typedef struct packed {
    logic                   start_req;
    logic signed [PotW-1:0] start_potential;
    logic signed [PotW-1:0] imbalance;
    logic [MagW-1:0]        source_magnitude;
  } item_t;

  typedef struct packed {
    logic signed [PotW-1:0] next_potential;
    status_t                status;
    logic [IterW-1:0]       iteration_count;
    logic signed [PotW-1:0] best_imbalance_out;
  } result_t;

endpackage

[src/bbrs_cfg.sv]
module bbrs_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_addr,
  input  logic [31:0]          cfg_data,
  output bbrs_pkg::cfg_t       cfg
);
  import bbrs_pkg::*;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_step   <= 31'd65536;
      cfg.max_step       <= 31'd1048576;
      cfg.max_iterations <= 16'd50;
      cfg.abs_tolerance  <= 31'd66;
      cfg.rel_tolerance  <= 16'd66;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_INITIAL_STEP:   cfg.initial_step   <= cfg_data[MagW-1:0];
        REG_MAX_STEP:       cfg.max_step       <= cfg_data[MagW-1:0];
        REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[IterW-1:0];
        REG_ABS_TOLERANCE:  cfg.abs_tolerance  <= cfg_data[MagW-1:0];
        REG_REL_TOLERANCE:  cfg.rel_tolerance  <= cfg_data[FracW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/bbrs_core.sv]
module bbrs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  bbrs_pkg::item_t   item,
  input  bbrs_pkg::cfg_t    cfg,
  output bbrs_pkg::result_t result
);
  import bbrs_pkg::*;

  // Search state.
  logic signed [PotW-1:0] current_potential, current_potential_next;
  logic [MagW-1:0]        step_size, step_size_next;
  logic signed [PotW-1:0] best_potential, best_potential_next;
  logic signed [PotW-1:0] best_imbalance, best_imbalance_next;
  logic signed [PotW-1:0] pos_potential, pos_potential_next;
  logic signed [PotW-1:0] neg_potential, neg_potential_next;
  logic                   have_pos, have_pos_next;
  logic                   have_neg, have_neg_next;
  logic [IterW-1:0]       iteration, iteration_next;
  logic                   searching, searching_next;

  // Working values.
  logic [MagW+FracW-1:0]  rel_product;
  logic [MagW-1:0]        rel_tol;
  logic [MagW-1:0]        tol;
  logic signed [PotW:0]   imb_wide;
  logic signed [PotW:0]   tol_wide;
  logic [PotW-1:0]        imb_mag;
  logic [PotW-1:0]        best_mag;
  logic                   above;
  logic                   below;
  logic [MagW:0]          step_double;
  logic signed [PotW:0]   step_sum;
  logic signed [PotW-1:0] step_sat;
  logic signed [PotW:0]   mid_sum;
  logic signed [PotW:0]   mid_shift;

  // Tolerance is the larger of the absolute and relative limits.
  always_comb begin
    rel_product = cfg.rel_tolerance * item.source_magnitude;
    rel_tol     = rel_product[MagW+FracW-1:FracW];
    tol         = (rel_tol > cfg.abs_tolerance) ? rel_tol : cfg.abs_tolerance;
    imb_wide    = {item.imbalance[PotW-1], item.imbalance};
    tol_wide    = $signed({2'b00, tol});
    above       = imb_wide > tol_wide;
    below       = imb_wide < -tol_wide;
    imb_mag     = item.imbalance[PotW-1] ? -item.imbalance : item.imbalance;
  end

  always_comb begin
    current_potential_next = current_potential;
    step_size_next         = step_size;
    best_potential_next    = best_potential;
    best_imbalance_next    = best_imbalance;
    pos_potential_next     = pos_potential;
    neg_potential_next     = neg_potential;
    have_pos_next          = have_pos;
    have_neg_next          = have_neg;
    iteration_next         = iteration;
    searching_next         = searching;
    result.next_potential  = current_potential;
    result.status          = ST_IDLE;
    best_mag               = '0;
    step_double            = '0;
    step_sum               = '0;
    step_sat               = '0;
    mid_sum                = '0;
    mid_shift              = '0;

    // A start item restarts the search at once.
    if (item.start_req) begin
      current_potential_next = item.start_potential;
      best_potential_next    = item.start_potential;
      best_imbalance_next    = GreatQ;
      have_pos_next          = 1'b0;
      have_neg_next          = 1'b0;
      iteration_next         = '0;
      step_size_next         = cfg.initial_step;
      searching_next         = 1'b1;
    end

    if (searching_next) begin
      // Track the point with the smallest imbalance magnitude.
      best_mag = best_imbalance_next[PotW-1] ? -best_imbalance_next : best_imbalance_next;
      if (imb_mag < best_mag) begin
        best_potential_next = current_potential_next;
        best_imbalance_next = item.imbalance;
      end

      // Record which side of the root this point lies on.
      if (above) begin
        pos_potential_next = current_potential_next;
        have_pos_next      = 1'b1;
      end else if (below) begin
        neg_potential_next = current_potential_next;
        have_neg_next      = 1'b1;
      end

      // Decide the next move.
      step_double = {step_size_next, 1'b0};
      step_sum = item.imbalance[PotW-1] || (item.imbalance == '0)
               ? {current_potential_next[PotW-1], current_potential_next}
                 - $signed({2'b00, step_size_next})
               : {current_potential_next[PotW-1], current_potential_next}
                 + $signed({2'b00, step_size_next});
      if (step_sum > $signed({1'b0, GreatQ}))
        step_sat = GreatQ;
      else if (step_sum < $signed({1'b1, MinQ}))
        step_sat = MinQ;
      else
        step_sat = step_sum[PotW-1:0];
      mid_sum   = {pos_potential_next[PotW-1], pos_potential_next}
                + {neg_potential_next[PotW-1], neg_potential_next};
      mid_shift = mid_sum >>> 1;

      priority if (!above && !below) begin
        result.status         = ST_CONVERGED;
        result.next_potential = current_potential_next;
        searching_next        = 1'b0;
      end else if (iteration_next >= cfg.max_iterations) begin
        result.status          = ST_FAILED;
        current_potential_next = best_potential_next;
        result.next_potential  = best_potential_next;
        searching_next         = 1'b0;
      end else if (!(have_pos_next && have_neg_next)) begin
        iteration_next         = iteration_next + 1'b1;
        current_potential_next = step_sat;
        result.next_potential  = step_sat;
        result.status          = ST_TRY;
        step_size_next         = (step_double < {1'b0, cfg.max_step})
                               ? step_double[MagW-1:0] : cfg.max_step;
      end else begin
        iteration_next         = iteration_next + 1'b1;
        current_potential_next = mid_shift[PotW-1:0];
        result.next_potential  = mid_shift[PotW-1:0];
        result.status          = ST_TRY;
      end
    end

    result.iteration_count    = iteration_next;
    result.best_imbalance_out = best_imbalance_next;
  end

  // State advances once for every item processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_potential <= '0;
      step_size         <= '0;
      best_potential    <= '0;
      best_imbalance    <= GreatQ;
      pos_potential     <= '0;
      neg_potential     <= '0;
      have_pos          <= 1'b0;
      have_neg          <= 1'b0;
      iteration         <= '0;
      searching         <= 1'b0;
    end else if (fire) begin
      current_potential <= current_potential_next;
      step_size         <= step_size_next;
      best_potential    <= best_potential_next;
      best_imbalance    <= best_imbalance_next;
      pos_potential     <= pos_potential_next;
      neg_potential     <= neg_potential_next;
      have_pos          <= have_pos_next;
      have_neg          <= have_neg_next;
      iteration         <= iteration_next;
      searching         <= searching_next;
    end
  end

endmodule

[src/bracket_bisect_root_search.sv]
// Bracketing and bisection root search on a monotonic imbalance curve.
// Each input item reports the imbalance measured at the last proposed
// potential; a start item also gives the starting potential and restarts
// the search. Every accepted item yields exactly one result item holding
// the next potential, the status (try next, converged, failed, idle), the
// iteration count and the best imbalance seen so far.
// The input item is registered, evaluated against the search state by
// combinational logic and written to the result register, which raises
// out_valid. One item is accepted per cycle while the receiver does not
// stall. The rate is set by the single evaluation stage, which updates
// the state for each item that moves on.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready drops only when both hold an item.
// Configuration writes on the cfg channel are always accepted and should
// be issued only while no item is in flight.
// Synchronous reset clears the valid flags of both registers and the
// search state and loads the configuration defaults.
module bracket_bisect_root_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               start_req,
  input  logic signed [31:0] start_potential,
  input  logic signed [31:0] imbalance,
  input  logic [30:0]        source_magnitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] next_potential,
  output logic [1:0]         status,
  output logic [15:0]        iteration_count,
  output logic signed [31:0] best_imbalance_out
);
  import bbrs_pkg::*;

  cfg_t    cfg;
  item_t   item_reg;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t result_reg;

  bbrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The registered item moves on when the result register is free.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_reg.start_req        <= start_req;
      item_reg.start_potential  <= start_potential;
      item_reg.imbalance        <= imbalance;
      item_reg.source_magnitude <= source_magnitude;
    end
  end

  bbrs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item_reg),
    .cfg    (cfg),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result;
    end
  end

  assign next_potential     = result_reg.next_potential;
  assign status             = result_reg.status;
  assign iteration_count    = result_reg.iteration_count;
  assign best_imbalance_out = result_reg.best_imbalance_out;

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbrs_pkg::*;

  localparam int RandomItems = 400;
  localparam int PhaseCount  = 6;
  localparam int IdleLimit   = 5000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_addr = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               start_req = 1'b0;
  logic signed [31:0] start_potential = '0;
  logic signed [31:0] imbalance = '0;
  logic [30:0]        source_magnitude = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] next_potential;
  logic [1:0]         status;
  logic [15:0]        iteration_count;
  logic signed [31:0] best_imbalance_out;

  bracket_bisect_root_search uut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_addr           (cfg_addr),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .start_req          (start_req),
    .start_potential    (start_potential),
    .imbalance          (imbalance),
    .source_magnitude   (source_magnitude),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .next_potential     (next_potential),
    .status             (status),
    .iteration_count    (iteration_count),
    .best_imbalance_out (best_imbalance_out)
  );

  // Clamp a wide value into the signed 32-bit Q16.16 range.
  function automatic longint clamp_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Tracks the search state, predicts one result item per accepted item and
  // compares the block's results against those predictions in order.
  class bisect_scoreboard;
    longint  init_step, step_cap, iter_limit, abs_tol, rel_tol;
    longint  cur_pot, step, best_pot, best_imb, pos_pot, neg_pot;
    bit      have_pos, have_neg, searching;
    int      iter;
    int      mismatches;
    result_t expected_results[$];

    function new();
      init_step  = 65536;
      step_cap   = 1048576;
      iter_limit = 50;
      abs_tol    = 66;
      rel_tol    = 66;
      cur_pot    = 0;
      step       = 0;
      best_pot   = 0;
      best_imb   = 64'sd2147483647;
      pos_pot    = 0;
      neg_pot    = 0;
      have_pos   = 1'b0;
      have_neg   = 1'b0;
      searching  = 1'b0;
      iter       = 0;
      mismatches = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [31:0] data);
      case (idx)
        REG_INITIAL_STEP:   init_step  = longint'(data[30:0]);
        REG_MAX_STEP:       step_cap   = longint'(data[30:0]);
        REG_MAX_ITERATIONS: iter_limit = longint'(data[15:0]);
        REG_ABS_TOLERANCE:  abs_tol    = longint'(data[30:0]);
        REG_REL_TOLERANCE:  rel_tol    = longint'(data[15:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Work out the result of one accepted measurement and queue it.
    function void note_measurement(item_t it);
      result_t r;
      longint  imb, relp, tol, nxt, dbl;
      imb = longint'($signed(it.imbalance));
      nxt = cur_pot;
      r.status = ST_IDLE;

      // A start item restarts the search even when one is active.
      if (it.start_req) begin
        cur_pot   = longint'($signed(it.start_potential));
        best_pot  = cur_pot;
        best_imb  = 64'sd2147483647;
        have_pos  = 1'b0;
        have_neg  = 1'b0;
        iter      = 0;
        step      = init_step;
        searching = 1'b1;
      end

      if (searching) begin
        relp = (rel_tol * longint'(it.source_magnitude)) >>> 16;
        tol  = (relp > abs_tol) ? relp : abs_tol;

        if ((imb < 0 ? -imb : imb) < (best_imb < 0 ? -best_imb : best_imb)) begin
          best_pot = cur_pot;
          best_imb = imb;
        end

        if (imb > tol) begin
          pos_pot  = cur_pot;
          have_pos = 1'b1;
        end else if (imb < -tol) begin
          neg_pot  = cur_pot;
          have_neg = 1'b1;
        end

        if (imb <= tol && imb >= -tol) begin
          r.status  = ST_CONVERGED;
          nxt       = cur_pot;
          searching = 1'b0;
        end else if (longint'(iter) >= iter_limit) begin
          r.status  = ST_FAILED;
          cur_pot   = best_pot;
          nxt       = best_pot;
          searching = 1'b0;
        end else if (!(have_pos && have_neg)) begin
          // Still bracketing: step toward the root and double the step, up to the cap.
          dbl  = step * 2;
          iter = iter + 1;
          nxt  = (imb > 0) ? clamp_q(cur_pot + step) : clamp_q(cur_pot - step);
          cur_pot  = nxt;
          step     = (dbl < step_cap) ? dbl : step_cap;
          r.status = ST_TRY;
        end else begin
          // Bracketed: propose the floored midpoint.
          iter     = iter + 1;
          nxt      = (pos_pot + neg_pot) >>> 1;
          cur_pot  = nxt;
          r.status = ST_TRY;
        end
      end

      r.next_potential     = nxt[31:0];
      r.iteration_count    = iter[15:0];
      r.best_imbalance_out = best_imb[31:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result item with no prediction waiting");
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.next_potential !== want.next_potential) begin
        $error("next_potential: expected %0d, actual %0d",
               want.next_potential, got.next_potential);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.iteration_count !== want.iteration_count) begin
        $error("iteration_count: expected %0d, actual %0d",
               want.iteration_count, got.iteration_count);
        mismatches++;
      end
      if (got.best_imbalance_out !== want.best_imbalance_out) begin
        $error("best_imbalance_out: expected %0d, actual %0d",
               want.best_imbalance_out, got.best_imbalance_out);
        mismatches++;
      end
    endfunction
  endclass

  bisect_scoreboard sb;

  int gap_pct   = 20;
  int stall_pct = 49;
  int idle_cycles = 0;

  // Parameters of the monotonic curve that the current search is run on.
  longint root;
  int     gain;
  int     gain_shift;
  logic [30:0] search_magnitude;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random by the current percentage.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every accepted result item.
  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got.next_potential     = next_potential;
      got.status             = status_t'(status);
      got.iteration_count    = iteration_count;
      got.best_imbalance_out = best_imbalance_out;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one item and hold it until it is accepted.
  task automatic send_item(logic s, logic [31:0] spot, logic [31:0] imb, logic [30:0] magn);
    item_t it;
    it.start_req        = s;
    it.start_potential  = spot;
    it.imbalance        = imb;
    it.source_magnitude = magn;
    // Before each item the sender stays idle at random, by the percentage gap_pct.
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    start_req        <= s;
    start_potential  <= spot;
    imbalance        <= imb;
    source_magnitude <= magn;
    do @(posedge clk); while (!in_ready);
    sb.note_measurement(it);
  endtask

  task automatic write_reg(reg_index_t idx, logic [30:0] value);
    logic [31:0] data;
    // Upper bits beyond the register width carry random junk.
    data = $urandom();
    case (idx)
      REG_MAX_ITERATIONS, REG_REL_TOLERANCE: data[15:0] = value[15:0];
      default: data[30:0] = value;
    endcase
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
  endtask

  // Drain the block, then load all five registers.
  task automatic write_config(logic [30:0] istep, logic [30:0] mstep, logic [15:0] miter,
                              logic [30:0] atol, logic [15:0] rtol);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_INITIAL_STEP, istep);
    write_reg(REG_MAX_STEP, mstep);
    write_reg(REG_MAX_ITERATIONS, {15'd0, miter});
    write_reg(REG_ABS_TOLERANCE, atol);
    write_reg(REG_REL_TOLERANCE, {15'd0, rtol});
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_phase(int p);
    case (p)
      0: write_config(31'd65536, 31'd1048576, 16'd50, 31'd66, 16'd66);
      1: write_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 31'd0, 16'hFFFF);
      2: write_config(31'd0, 31'd0, 16'd0, 31'h7FFF_FFFF, 16'd0);
      3: write_config(31'($urandom_range(1, 1 << 20)), 31'($urandom_range(1, 1 << 24)),
                      16'($urandom_range(5, 40)), 31'($urandom_range(0, 4096)),
                      16'($urandom()));
      4: write_config(31'($urandom()), 31'($urandom()), 16'($urandom_range(0, 100)),
                      31'($urandom()), 16'($urandom()));
      default: write_config(31'd1, 31'd65536, 16'd30, 31'd0, 16'd0);
    endcase
  endtask

  // Imbalance of the current curve at a potential; it falls as potential rises.
  function automatic logic [31:0] measure(longint pot);
    longint v;
    v = clamp_q(((root - pot) * gain) >>> gain_shift);
    return v[31:0];
  endfunction

  task automatic begin_search();
    longint spot;
    root = ($urandom_range(3) == 0) ? longint'($signed($urandom()))
                                    : longint'($urandom_range(0, 2000000)) - 1000000;
    gain       = $urandom_range(1, 255);
    gain_shift = $urandom_range(0, 8);
    case ($urandom_range(2))
      0:       search_magnitude = '0;
      1:       search_magnitude = 31'($urandom());
      default: search_magnitude = 31'($urandom_range(0, 1 << 20));
    endcase
    spot = clamp_q(root + (longint'($signed($urandom())) >>> $urandom_range(4, 20)));
    send_item(1'b1, spot[31:0], measure(spot), search_magnitude);
  endtask

  initial begin
    int counted;
    int phase;
    int search_left;
    logic [31:0] noise;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset configuration.
    send_item(1'b0, $urandom(), 32'd123, 31'd0);                 // idle before any search
    send_item(1'b1, 32'd0, 32'd0, 31'd0);                        // converges at once
    send_item(1'b0, $urandom(), $urandom(), 31'($urandom()));    // idle after convergence
    send_item(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF); // step saturates high
    send_item(1'b0, 32'd0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(1'b0, 32'd0, 32'h8000_0000, 31'd0);                // brackets, bisects
    send_item(1'b0, 32'd0, 32'd5, 31'd0);                        // within tolerance
    send_item(1'b1, 32'h8000_0000, 32'h8000_0000, 31'd0);        // step saturates low
    send_item(1'b0, 32'd0, 32'd1000, 31'd0);
    send_item(1'b0, 32'd0, -32'sd1000, 31'd0);
    send_item(1'b1, 32'd1000, 32'd66, 31'd0);                    // exactly at tolerance
    send_item(1'b1, 32'd1000, 32'd67, 31'd0);                    // just above tolerance
    send_item(1'b0, 32'd0, -32'sd66, 31'd0);
    send_item(1'b1, -32'sd5000, -32'sd67, 31'd0);
    send_item(1'b0, 32'd0, 32'd67, 31'd0);
    send_item(1'b1, 32'd42, 32'd300000, 31'd0);
    send_item(1'b0, 32'd0, 32'd300000, 31'd0);
    send_item(1'b1, 32'd7, 32'd300000, 31'd0);                   // restart mid-search
    send_item(1'b0, 32'd0, 32'd500000, 31'h7FFF_FFFF);           // relative tolerance wins

    // First step above the cap, zero later steps, then failure at the limit.
    write_config(31'h7FFF_FFFF, 31'd0, 16'd2, 31'd0, 16'd0);
    send_item(1'b1, 32'd0, 32'd5, 31'd0);
    send_item(1'b0, 32'd0, 32'd5, 31'd0);
    send_item(1'b0, 32'd0, 32'd5, 31'd0);
    send_item(1'b0, $urandom(), $urandom(), 31'($urandom()));

    // Random searches over several register settings.
    counted     = 0;
    phase       = 0;
    search_left = 0;
    apply_phase(0);
    while (counted < RandomItems) begin
      if (phase < PhaseCount - 1 && counted >= (phase + 1) * RandomItems / PhaseCount) begin
        phase++;
        apply_phase(phase);
      end
      case (counted * 3 / RandomItems)
        0:       begin gap_pct = 20; stall_pct = 49; end
        1:       begin gap_pct = 49; stall_pct = 20; end
        default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase

      if (!sb.searching && $urandom_range(99) < 15) begin
        // Idle items between searches.
        send_item(1'b0, $urandom(), $urandom(), 31'($urandom()));
      end else if (!sb.searching || search_left == 0) begin
        begin_search();
        search_left = $urandom_range(5, 80);
        counted++;
      end else begin
        search_left--;
        counted++;
        if ($urandom_range(99) < 8) begin
          noise = $urandom();
          send_item(noise[0], $urandom(), $urandom(), 31'($urandom()));
        end else begin
          send_item(1'b0, $urandom(), measure(sb.cur_pot), search_magnitude);
        end
      end
    end

    // Drain and finish.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
